/* rtl/core/htwd_pkg.sv */
package htwd_pkg;

  // Field widths of the stream items and registers.
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 4;
  localparam int FUNC_W  = 2;
  localparam int LIMIT_W = 32;
  localparam int BYTE_W  = 8;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 8;
  localparam int USER_W  = 2;

  // Bits per data byte and the position of its first bit.
  localparam int BYTE_BITS = 8;
  localparam int TOP_BIT   = 7;

  localparam int DEF_NODE_DEPTH = 512;

  // Item kinds carried on the slave tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LIMIT = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic latch_root;
    logic latch_cur;
    logic emit_root;
    logic issue_next;
    logic take_next;
    logic flush;
  } htwd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tree_empty;
    logic bits_done;
    logic limit_hit;
    logic root_leaf;
    logic room;
    logic pend_valid;
  } htwd_stat_t;

endpackage

/* rtl/core/htwd_ctrl.sv */
module htwd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [htwd_pkg::FUNC_W-1:0]     in_func,
  output logic                            in_ready,
  input  htwd_pkg::htwd_stat_t            stat,
  output htwd_pkg::htwd_cmd_t             cmd
);
  import htwd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROOT  = 3'd1;
  localparam logic [2:0] ST_CUR   = 3'd2;
  localparam logic [2:0] ST_BIT   = 3'd3;
  localparam logic [2:0] ST_NEXT  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            FUNC_LOAD:    cmd.load = 1'b1;
            FUNC_RESTART: cmd.restart = 1'b1;
            FUNC_DATA: begin
              cmd.start  = 1'b1;
              state_next = stat.tree_empty ? ST_DRAIN : ST_ROOT;
            end
            default: ;
          endcase
        end
      end
      ST_ROOT: begin
        cmd.latch_root = 1'b1;
        state_next     = ST_CUR;
      end
      ST_CUR: begin
        cmd.latch_cur = 1'b1;
        state_next    = ST_BIT;
      end
      ST_BIT: begin
        if (stat.bits_done || stat.limit_hit) begin
          state_next = ST_DRAIN;
        end else if (stat.room) begin
          if (stat.root_leaf) begin
            cmd.emit_root = 1'b1;
          end else begin
            cmd.issue_next = 1'b1;
            state_next     = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        cmd.take_next = 1'b1;
        state_next    = ST_BIT;
      end
      ST_DRAIN: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.room) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/htwd_datapath.sv */
module htwd_datapath #(
  parameter int NODE_DEPTH = htwd_pkg::DEF_NODE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htwd_pkg::LIMIT_W-1:0]      cfg_data,
  input  logic [htwd_pkg::IN_W-1:0]         in_data,
  input  htwd_pkg::htwd_cmd_t               cmd,
  output htwd_pkg::htwd_stat_t              stat,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [htwd_pkg::OUT_W-1:0]        m_tdata,
  output logic                              m_tlast,
  output logic [htwd_pkg::USER_W-1:0]       m_tuser
);
  import htwd_pkg::*;

  localparam int AW = $clog2(NODE_DEPTH);

  // Input fields.
  logic [IDX_W-1:0]  f_node_index;
  logic              f_node_leaf;
  logic [IDX_W-1:0]  f_left;
  logic [IDX_W-1:0]  f_right;
  logic [SYM_W-1:0]  f_symbol;
  logic [BYTE_W-1:0] f_data_byte;
  logic [CNT_W-1:0]  f_bit_count;

  assign f_node_index = in_data[8:0];
  assign f_node_leaf  = in_data[9];
  assign f_left       = in_data[18:10];
  assign f_right      = in_data[27:19];
  assign f_symbol     = in_data[35:28];
  assign f_data_byte  = in_data[43:36];
  assign f_bit_count  = in_data[47:44];

  // Configuration registers.
  logic [IDX_W-1:0]   node_count;
  logic [LIMIT_W-1:0] symbol_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= '0;
      symbol_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT:   node_count   <= cfg_data[IDX_W-1:0];
        REG_SYMBOL_LIMIT: symbol_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk state.
  logic [IDX_W-1:0]   walk_position;
  logic               at_root;
  logic [LIMIT_W-1:0] emitted_count;
  logic [BYTE_W-1:0]  data_sh;
  logic [CNT_W-1:0]   bits_left;
  node_t              root_node;
  node_t              cur_node;
  logic [IDX_W-1:0]   next_idx;
  logic [IDX_W-1:0]   root_idx;
  logic [IDX_W-1:0]   step_idx;

  assign root_idx = node_count - IDX_W'(1);
  assign step_idx = data_sh[TOP_BIT] ? cur_node.right : cur_node.left;

  // Node memory with one write port and one registered read port.
  node_t            node_mem [NODE_DEPTH];
  node_t            rd_data;
  logic             rd_oob;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  node_t            wr_node;
  node_t            node_rd;

  assign wr_en   = cmd.load && (32'(f_node_index) < 32'(NODE_DEPTH));
  assign wr_node = '{leaf: f_node_leaf, left: f_left, right: f_right, sym: f_symbol};

  always_comb begin
    rd_en  = cmd.start || cmd.latch_root || cmd.issue_next;
    rd_idx = root_idx;
    if (cmd.latch_root) begin
      rd_idx = walk_position;
    end else if (cmd.issue_next) begin
      rd_idx = step_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[AW'(f_node_index)] <= wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= node_mem[AW'(rd_idx)];
      rd_oob  <= !(32'(rd_idx) < 32'(NODE_DEPTH));
    end
  end

  // Indices beyond the memory read as an all-zero node.
  assign node_rd = rd_oob ? '0 : rd_data;

  // Result staging: the newest symbol waits in a pending register until the
  // next one (or the end of the item) tells whether it is the last of its run.
  logic             push_sym;
  logic [SYM_W-1:0] push_val;
  logic [LIMIT_W-1:0] count_inc;
  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_fin;
  logic             pend_err;
  logic             push_out;

  assign push_sym  = cmd.emit_root || (cmd.take_next && node_rd.leaf);
  assign push_val  = cmd.emit_root ? root_node.sym : node_rd.sym;
  assign count_inc = emitted_count + LIMIT_W'(1);
  assign push_out  = (push_sym && pend_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (push_sym || (cmd.start && stat.tree_empty)) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_sym <= '0;
      pend_fin <= 1'b0;
      pend_err <= 1'b1;
    end
    if (push_sym) begin
      pend_sym <= push_val;
      pend_fin <= (count_inc == symbol_limit);
      pend_err <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      m_tdata <= pend_sym;
      m_tlast <= cmd.flush;
      m_tuser <= {pend_err, pend_fin};
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_position <= '0;
      at_root       <= 1'b1;
      emitted_count <= '0;
      bits_left     <= '0;
    end else begin
      if (cmd.restart) begin
        at_root       <= 1'b1;
        emitted_count <= '0;
      end
      if (cmd.start) begin
        bits_left <= (f_bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : f_bit_count;
      end
      if (cmd.emit_root || cmd.take_next) begin
        bits_left <= bits_left - CNT_W'(1);
      end
      if (push_sym) begin
        emitted_count <= count_inc;
        at_root       <= 1'b1;
      end else if (cmd.take_next) begin
        walk_position <= next_idx;
        at_root       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      data_sh <= f_data_byte;
    end else if (cmd.emit_root || cmd.take_next) begin
      data_sh <= {data_sh[BYTE_W-2:0], 1'b0};
    end
    if (cmd.latch_root) begin
      root_node <= node_rd;
    end
    if (cmd.issue_next) begin
      next_idx <= step_idx;
    end
    if (cmd.latch_cur) begin
      cur_node <= at_root ? root_node : node_rd;
    end else if (push_sym) begin
      cur_node <= root_node;
    end else if (cmd.take_next) begin
      cur_node <= node_rd;
    end
  end

  assign stat.tree_empty = (node_count == '0);
  assign stat.bits_done  = (bits_left == '0);
  assign stat.limit_hit  = (emitted_count >= symbol_limit);
  assign stat.root_leaf  = root_node.leaf;
  assign stat.room       = !pend_valid || !m_tvalid || m_tready;
  assign stat.pend_valid = pend_valid;

endmodule

/* rtl/core/huffman_tree_walk_decoder.sv */
// Load and restart transfers are taken in the idle state. A data transfer reads the root node,
// then the current node, then walks one step per consumed bit; each bit below a non-leaf root
// waits on one registered read of the node memory, and a held output register stalls the walk.
// With no tree loaded, a data transfer goes straight to the drain and returns an error result.
// Results leave through an output register, one symbol behind the walk, up to 8 per item.
// Reset (synchronous, active high) clears the configuration, the walk and the symbol count;
// the node memory keeps its contents and is undefined until loaded.
module huffman_tree_walk_decoder #(
  parameter int NODE_DEPTH = htwd_pkg::DEF_NODE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port: index 0 is node_count, index 1 is symbol_limit.
  input  logic                            cfg_we,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htwd_pkg::LIMIT_W-1:0]    cfg_data,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata from bit 0: node_index, node_leaf, left_child, right_child, node_symbol,
  // data_byte, bit_count.
  input  logic [htwd_pkg::IN_W-1:0]       s_tdata,
  // tuser: func.
  input  logic [htwd_pkg::FUNC_W-1:0]     s_tuser,
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: symbol.
  output logic [htwd_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast,
  // tuser from bit 0: finished, no_tree.
  output logic [htwd_pkg::USER_W-1:0]     m_tuser
);
  import htwd_pkg::*;

  htwd_cmd_t  cmd;
  htwd_stat_t stat;

  // The controller sequences one transfer at a time: it accepts a new item only in its
  // idle state, and steps through the root read, the current-node read and one memory
  // read per bit below a non-leaf root. It holds a step whenever a symbol would overwrite
  // a result that the output register has not yet handed on.
  htwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the node memory, the walk position, the symbol count and the
  // result staging. The newest symbol waits in a pending register so that the end of
  // the run is known before it is marked with tlast.
  htwd_datapath #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // An error result is alone in its run, carries symbol zero and is never finished.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == '0) && !m_tuser[0])
    else $error("error result with bad companion fields");

  // A new item is never taken while a symbol of the previous one is still pending.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.pend_valid)
    else $error("input accepted with a pending result");

  // The output register is only ever filled from the pending register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.pend_valid))
    else $error("output filled without a pending result");

endmodule
